// ----- sv/rms_level_detector_dc_removal_defines.svh -----
// ----------------------------------------------------------------------------
// RMS level detector assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef RMS_LEVEL_DETECTOR_DC_REMOVAL_DEFINES_SVH
`define RMS_LEVEL_DETECTOR_DC_REMOVAL_DEFINES_SVH

// Check a consequence in the same cycle as its trigger
`define RLD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger
`define RLD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/rld_pkg.sv -----
// ----------------------------------------------------------------------------
// RMS level detector package
// Widths, register codes, reset values and the result bundle of the root unit.
// ----------------------------------------------------------------------------
package rld_pkg;

  // Datapath widths
  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 40;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int LEVEL_W  = 16;
  localparam int SUB_W    = 24;
  localparam int STEP_W   = 6;

  // Iteration counts of the shared subtractor
  localparam int DIV_STEPS  = SUM_W;
  localparam int ROOT_STEPS = ROOT_W;

  // Configuration register codes
  localparam logic [3:0] CFG_DECIMATION = 4'd0;
  localparam logic [3:0] CFG_WINDOW_LEN = 4'd1;
  localparam logic [3:0] CFG_MAX_KEPT   = 4'd2;
  localparam logic [3:0] CFG_THRESHOLD  = 4'd3;

  // Configuration reset values
  localparam logic [6:0]  DECIMATION_RST = 7'd16;
  localparam logic [12:0] WINDOW_LEN_RST = 13'd512;
  localparam logic [7:0]  MAX_KEPT_RST   = 8'd128;
  localparam logic [15:0] THRESHOLD_RST  = 16'd130;

  // Decimation limits
  localparam logic [6:0] DEC_MAX = 7'd64;

  // Result of the divide and root unit
  typedef struct packed {
    logic               done;
    logic               loud;
    logic [LEVEL_W-1:0] level;
  } dr_result_t;

endpackage

// ----- sv/rld_divroot.sv -----
// ----------------------------------------------------------------------------
// RMS level detector divide and root unit
// Restoring division of the square sum by the kept count, then a digit-by-digit
// square root of the quotient, both on one shared subtractor.
// ----------------------------------------------------------------------------
module rld_divroot
  import rld_pkg::*;
#(
  parameter int DIV_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  input  logic [31:0]      thr_sq,
  output dr_result_t       result
);

  typedef enum logic [2:0] {
    DR_IDLE = 3'b001,
    DR_DIV  = 3'b010,
    DR_ROOT = 3'b100
  } dr_state_t;

  dr_state_t         state;
  logic [SUM_W-1:0]  work;
  logic [SUB_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [STEP_W-1:0] step;
  logic              loud;
  logic              done;

  logic [SUB_W-1:0]  op_a;
  logic [SUB_W-1:0]  op_b;
  logic [SUB_W:0]    diff;
  logic              fits;
  logic [SUB_W-1:0]  rem_next;
  logic [SUM_W-1:0]  quot_next;
  logic [SUM_W-1:0]  thr_ext;

  // Shared subtractor: trial divisor or trial root
  always_comb begin
    if (state == DR_ROOT) begin
      op_a = {rem[SUB_W-3:0], work[SUM_W-1 -: 2]};
      op_b = SUB_W'({root, 2'b01});
    end else begin
      op_a = {rem[SUB_W-2:0], work[SUM_W-1]};
      op_b = SUB_W'(divisor);
    end
    diff      = {1'b0, op_a} - {1'b0, op_b};
    fits      = ~diff[SUB_W];
    rem_next  = fits ? diff[SUB_W-1:0] : op_a;
    quot_next = {work[SUM_W-2:0], fits};
    thr_ext   = SUM_W'(thr_sq);
  end

  // Sequence the division and root steps
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DR_IDLE;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        DR_IDLE: begin
          if (start) begin
            state <= DR_DIV;
            step  <= '0;
          end
        end
        DR_DIV: begin
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= DR_ROOT;
            step  <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        DR_ROOT: begin
          if (step == STEP_W'(ROOT_STEPS - 1)) begin
            state <= DR_IDLE;
            done  <= 1'b1;
          end else begin
            step <= step + 1'b1;
          end
        end
        default: begin
          state <= DR_IDLE;
        end
      endcase
    end
  end

  // Advance the working registers
  always_ff @(posedge clk) begin
    case (state)
      DR_IDLE: begin
        if (start) begin
          work <= dividend;
          rem  <= '0;
        end
      end
      DR_DIV: begin
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          work <= quot_next;
          rem  <= '0;
          root <= '0;
          loud <= (quot_next > thr_ext) ||
                  ((quot_next == thr_ext) && (rem_next != '0));
        end else begin
          work <= quot_next;
          rem  <= rem_next;
        end
      end
      DR_ROOT: begin
        rem  <= rem_next;
        root <= {root[ROOT_W-2:0], fits};
        work <= {work[SUM_W-3:0], 2'b00};
      end
      default: begin
        rem <= '0;
      end
    endcase
  end

  // Saturate the root to the level width
  always_comb begin
    result.done  = done;
    result.loud  = loud;
    result.level = (root > ROOT_W'({LEVEL_W{1'b1}})) ? {LEVEL_W{1'b1}} : root[LEVEL_W-1:0];
  end

endmodule

// ----- sv/rms_level_detector_dc_removal.sv -----
// ----------------------------------------------------------------------------
// RMS level detector with DC removal
// Decimates raw microphone words per window, removes a running DC estimate,
// sums exact squares and reports the window's RMS level and a loud flag.
// ----------------------------------------------------------------------------
// A dropped sample is handled in the idle state alone; a kept sample passes
// through accept, DC update, square on the shared multiplier and saturating
// accumulate. At the last raw sample of a window the block then squares the
// threshold, runs 40 restoring division steps and 20 square root steps on the
// single subtractor in rld_divroot, hands the result back and loads the output
// register.
// s_axis_tready is low while an item is in work. A finished result waits in
// the output register while the next samples are taken; a second window end
// holds until that result has been taken.
module rms_level_detector_dc_removal
  import rld_pkg::*;
#(
  parameter int MAX_WINDOW = 4096,
  parameter int MAX_KEPT   = 128
) (
  input  logic        clk,
  input  logic        rst,
  // Sample stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] raw_word
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] rms_level
  output logic        m_axis_tuser,   // [0] loud
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  `include "rms_level_detector_dc_removal_defines.svh"

  localparam int POS_W = $clog2(MAX_WINDOW + 1);
  localparam int KC_W  = $clog2(MAX_KEPT + 1);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DC   = 7'b0000010,
    ST_SQ   = 7'b0000100,
    ST_ACC  = 7'b0001000,
    ST_THR  = 7'b0010000,
    ST_CALC = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  state_t state;

  // Configuration registers
  logic [6:0]  decimation;
  logic [12:0] window_length;
  logic [7:0]  max_kept;
  logic [15:0] level_threshold;

  // Window state
  logic signed [SAMPLE_W-1:0] dc_estimate;
  logic [POS_W-1:0]           position;
  logic [5:0]                 phase;
  logic [KC_W-1:0]            kept;
  logic [SUM_W-1:0]           square_sum;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       wend;
  logic [31:0]                prod;

  // Effective limits
  logic [6:0]       dec_eff;
  logic [POS_W-1:0] wlen_eff;
  logic [KC_W-1:0]  cap_eff;
  logic [31:0]      wl32;
  logic [31:0]      mk32;

  logic                       accept;
  logic                       keep;
  logic [6:0]                 phase_inc;
  logic [POS_W-1:0]           pos_inc;
  logic signed [22:0]         dc_sum;
  logic signed [SAMPLE_W-1:0] dc_next;
  logic signed [16:0]         dfree;
  logic signed [16:0]         mult_a;
  logic signed [33:0]         mult_p;
  logic [SUM_W:0]             sum_add;
  logic                       out_load;
  logic                       calc_start;
  dr_result_t                 dr_res;

  // Clamp the configured limits
  always_comb begin
    wl32 = 32'(window_length);
    mk32 = 32'(max_kept);
    if (decimation == 7'd0) begin
      dec_eff = 7'd1;
    end else if (decimation > DEC_MAX) begin
      dec_eff = DEC_MAX;
    end else begin
      dec_eff = decimation;
    end
    if (wl32 == 32'd0) begin
      wlen_eff = POS_W'(1);
    end else if (wl32 > 32'(MAX_WINDOW)) begin
      wlen_eff = POS_W'(MAX_WINDOW);
    end else begin
      wlen_eff = POS_W'(wl32);
    end
    if (mk32 == 32'd0) begin
      cap_eff = KC_W'(1);
    end else if (mk32 > 32'(MAX_KEPT)) begin
      cap_eff = KC_W'(MAX_KEPT);
    end else begin
      cap_eff = KC_W'(mk32);
    end
  end

  // Per-sample decisions and arithmetic
  always_comb begin
    accept    = s_axis_tvalid && s_axis_tready;
    keep      = (phase == 6'd0) && (kept < cap_eff);
    phase_inc = {1'b0, phase} + 7'd1;
    pos_inc   = position + 1'b1;
    dc_sum    = (23'(dc_estimate) <<< 6) - 23'(dc_estimate) + 23'(sample);
    dc_next   = SAMPLE_W'(dc_sum >>> 6);
    dfree     = 17'(sample) - 17'(dc_estimate);
    mult_a    = (state == ST_SQ) ? dfree : signed'({1'b0, level_threshold});
    mult_p    = mult_a * mult_a;
    sum_add   = {1'b0, square_sum} + (SUM_W + 1)'(prod);
    out_load  = (state == ST_OUT) && (!m_axis_tvalid || m_axis_tready);
    calc_start = (state == ST_THR);
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      decimation      <= DECIMATION_RST;
      window_length   <= WINDOW_LEN_RST;
      max_kept        <= MAX_KEPT_RST;
      level_threshold <= THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DECIMATION: decimation      <= cfg_data[6:0];
        CFG_WINDOW_LEN: window_length   <= cfg_data[12:0];
        CFG_MAX_KEPT:   max_kept        <= cfg_data[7:0];
        CFG_THRESHOLD:  level_threshold <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequence one transaction through the shared multiplier and divider
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      dc_estimate <= '0;
      position    <= '0;
      phase       <= '0;
      kept        <= '0;
      square_sum  <= '0;
      wend        <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            phase    <= (phase_inc >= dec_eff) ? 6'd0 : phase_inc[5:0];
            position <= pos_inc;
            wend     <= (pos_inc >= wlen_eff);
            if (keep) begin
              state <= ST_DC;
            end else if (pos_inc >= wlen_eff) begin
              state <= ST_THR;
            end
          end
        end
        ST_DC: begin
          dc_estimate <= dc_next;
          state       <= ST_SQ;
        end
        ST_SQ: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          square_sum <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
          kept       <= kept + 1'b1;
          state      <= wend ? ST_THR : ST_IDLE;
        end
        ST_THR: begin
          state <= ST_CALC;
        end
        ST_CALC: begin
          if (dr_res.done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            position   <= '0;
            phase      <= '0;
            kept       <= '0;
            square_sum <= '0;
            wend       <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Hold the sample and the shared multiplier product
  always_ff @(posedge clk) begin
    if (accept) begin
      sample <= signed'(s_axis_tdata[31:16]);
    end
    if (state == ST_SQ || state == ST_THR) begin
      prod <= mult_p[31:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= (kept == '0) ? '0 : dr_res.level;
      m_axis_tuser <= (kept != '0) && dr_res.loud;
    end
  end

  rld_divroot #(
    .DIV_W (KC_W)
  ) u_divroot (
    .clk      (clk),
    .rst      (rst),
    .start    (calc_start),
    .dividend (square_sum),
    .divisor  (kept),
    .thr_sq   (prod),
    .result   (dr_res)
  );

  // Checks
  `RLD_ASSERT_SAME(a_kept_bound, 1'b1, kept <= KC_W'(MAX_KEPT), "kept count beyond capacity")
  `RLD_ASSERT_NEXT(a_calc_to_out, (state == ST_CALC) && dr_res.done, state == ST_OUT,
                   "root result not taken to output")
  `RLD_ASSERT_NEXT(a_out_loaded, out_load, m_axis_tvalid, "result lost at output load")
  `RLD_ASSERT_NEXT(a_window_clear, out_load,
                   (kept == '0) && (square_sum == '0) && (position == '0),
                   "window state not cleared after result")

endmodule
